FILE: hw/rtl/chbd_pkg.sv
// Shared types and constants for the bank and DMA register block.
package chbd_pkg;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [3:0] REG_VBANK = 4'd0;
    localparam logic [3:0] REG_SPEED = 4'd1;
    localparam logic [3:0] REG_DMA1  = 4'd2;
    localparam logic [3:0] REG_DMA2  = 4'd3;
    localparam logic [3:0] REG_DMA3  = 4'd4;
    localparam logic [3:0] REG_DMA4  = 4'd5;
    localparam logic [3:0] REG_DMA5  = 4'd6;
    localparam logic [3:0] REG_IR    = 4'd7;
    localparam logic [3:0] REG_WBANK = 4'd8;

    localparam logic [1:0] DMA_ERR_OK  = 2'd0;
    localparam logic [1:0] DMA_ERR_SRC = 2'd1;
    localparam logic [1:0] DMA_ERR_DST = 2'd2;

    localparam logic [15:0] SRC_BAD1_LO = 16'h7FF1;
    localparam logic [15:0] SRC_BAD1_HI = 16'h9FFF;
    localparam logic [15:0] SRC_BAD2_LO = 16'hDFF1;
    localparam logic [12:0] DST_OFS_MAX = 13'h1FF0;  // 0x9FF0 - 0x8000

    localparam logic [7:0] SRC_LO_MASK  = 8'hF0;
    localparam logic [4:0] DST_HI_MASK  = 5'h1F;
    localparam logic [7:0] DST_LO_MASK  = 8'hF0;
    localparam logic [6:0] LEN_MASK     = 7'h7F;
    localparam logic [7:0] CTRL_READ    = 8'hFF;
    localparam logic [6:0] VBANK_RD_FILL = 7'h7F;
    localparam logic [7:0] INV_READ_RST = 8'hFF;

    localparam int CFG_ADDR_W = 3;

    typedef struct packed {
        logic        start;
        logic [15:0] source;
        logic [15:0] dest;
        logic [11:0] length;
        logic [1:0]  error;
    } t_dma_req;

endpackage

FILE: hw/rtl/color_handheld_bank_and_dma_regs.sv
// Top level: bank, speed, infrared and DMA register block with APB config port.
//
// Usage: each request on the input channel is one bus access (command,
// reg_index, write_data). Every accepted request yields exactly one result
// on the output channel: read data plus the video and work bank selects,
// and for a write of the DMA control register the transfer request
// (start, source, destination, length, error code).
// A request accepted at a clock edge is loaded into the output register at
// that edge, and its result is offered on the output in the following cycle.
// Throughput is one request per cycle; all decode and range checks sit
// between the register state and the single output register.
// When the receiver stalls, the result holds in the output register and
// o_in_stall rises so no new request is taken until the result is gone;
// a result taken in the same cycle frees the register for the next request.
// Reset clears the bank, speed, DMA and infrared registers, empties the output
// register and sets the unknown-index read value to 0xFF. The APB port holds
// that one register at addresses 0 to 3; pready is always high.
module color_handheld_bank_and_dma_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [3:0]  i_reg_index,
    input  logic [7:0]  i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    output logic        o_vram_bank_sel,
    output logic [2:0]  o_wram_bank_sel,
    output logic        o_dma_start,
    output logic [15:0] o_dma_source,
    output logic [15:0] o_dma_dest,
    output logic [11:0] o_dma_length,
    output logic [1:0]  o_dma_error,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [chbd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import chbd_pkg::*;

    logic [7:0]  r_inv_read;
    logic        r_vbank,    n_vbank;
    logic [7:0]  r_speed,    n_speed;
    logic [15:0] r_src,      n_src;
    logic [12:0] r_dst,      n_dst;
    logic [7:0]  r_ir,       n_ir;
    logic [2:0]  r_wbank,    n_wbank;

    logic        r_out_valid;
    logic [7:0]  r_read_data, n_read_data;
    t_dma_req    r_dma,       n_dma;

    t_dma_req    chk_req;
    logic        in_acc;
    logic        cfg_wr;

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[CFG_ADDR_W-1] == 1'b0) ? {24'd0, r_inv_read} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_read <= INV_READ_RST;
        end else if (cfg_wr && paddr[CFG_ADDR_W-1] == 1'b0) begin
            r_inv_read <= pwdata[7:0];
        end
    end

    // ---------------- handshake ----------------
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_acc     = i_in_valid & ~o_in_stall;

    chbd_dma_check u_dma_check (
        .i_source   (r_src),
        .i_dest_ofs (r_dst),
        .i_ctrl     (i_write_data),
        .o_req      (chk_req)
    );

    always_comb begin
        n_vbank     = r_vbank;
        n_speed     = r_speed;
        n_src       = r_src;
        n_dst       = r_dst;
        n_ir        = r_ir;
        n_wbank     = r_wbank;
        n_read_data = 8'd0;
        n_dma       = '0;
        if (i_command == CMD_READ) begin
            case (i_reg_index)
                REG_VBANK: n_read_data = {VBANK_RD_FILL, r_vbank};
                REG_SPEED: n_read_data = r_speed;
                REG_DMA1:  n_read_data = r_src[15:8];
                REG_DMA2:  n_read_data = r_src[7:0];
                REG_DMA3:  n_read_data = {3'd0, r_dst[12:8]};
                REG_DMA4:  n_read_data = r_dst[7:0];
                REG_DMA5:  n_read_data = CTRL_READ;
                REG_IR:    n_read_data = r_ir;
                REG_WBANK: n_read_data = {5'd0, r_wbank};
                default:   n_read_data = r_inv_read;
            endcase
        end else begin
            case (i_reg_index)
                REG_VBANK: n_vbank = i_write_data[0];
                REG_SPEED: n_speed = i_write_data;
                REG_DMA1:  n_src[15:8] = i_write_data;
                REG_DMA2:  n_src[7:0] = i_write_data & SRC_LO_MASK;
                REG_DMA3:  n_dst[12:8] = i_write_data[4:0] & DST_HI_MASK;
                REG_DMA4:  n_dst[7:0] = i_write_data & DST_LO_MASK;
                REG_DMA5:  n_dma = chk_req;
                REG_IR:    n_ir = i_write_data;
                REG_WBANK: begin
                    // bank 0 maps to bank 1
                    n_wbank = (i_write_data[2:0] == 3'd0) ? 3'd1 : i_write_data[2:0];
                end
                default:   n_read_data = 8'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbank <= 1'b0;
            r_speed <= 8'd0;
            r_src   <= 16'd0;
            r_dst   <= 13'd0;
            r_ir    <= 8'd0;
            r_wbank <= 3'd0;
        end else if (in_acc) begin
            r_vbank <= n_vbank;
            r_speed <= n_speed;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_ir    <= n_ir;
            r_wbank <= n_wbank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload; bank selects show the state after this request
    logic r_vbank_out;
    logic [2:0] r_wbank_out;
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_read_data <= n_read_data;
            r_dma       <= n_dma;
            r_vbank_out <= n_vbank;
            r_wbank_out <= n_wbank;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_read_data;
    assign o_vram_bank_sel = r_vbank_out;
    assign o_wram_bank_sel = r_wbank_out;
    assign o_dma_start     = r_dma.start;
    assign o_dma_source    = r_dma.source;
    assign o_dma_dest      = r_dma.dest;
    assign o_dma_length    = r_dma.length;
    assign o_dma_error     = r_dma.error;

endmodule

FILE: hw/rtl/chbd_dma_check.sv
// DMA request builder: range checks on source and destination, transfer length.
module chbd_dma_check (
    input  logic [15:0]       i_source,
    input  logic [12:0]       i_dest_ofs,
    input  logic [7:0]        i_ctrl,
    output chbd_pkg::t_dma_req o_req
);
    import chbd_pkg::*;

    logic       src_bad;
    logic       dst_bad;
    logic [7:0] blocks;

    assign src_bad = (i_source >= SRC_BAD1_LO && i_source <= SRC_BAD1_HI)
                  || (i_source >= SRC_BAD2_LO);
    assign dst_bad = (i_dest_ofs > DST_OFS_MAX);
    // 1..128 blocks of 16 bytes
    assign blocks  = {1'b0, i_ctrl[6:0] & LEN_MASK} + 8'd1;

    always_comb begin
        o_req.source = i_source;
        o_req.dest   = {3'b100, i_dest_ofs};
        o_req.length = {blocks, 4'b0000};
        if (src_bad) begin
            o_req.error = DMA_ERR_SRC;
        end else if (dst_bad) begin
            o_req.error = DMA_ERR_DST;
        end else begin
            o_req.error = DMA_ERR_OK;
        end
        o_req.start = (o_req.error == DMA_ERR_OK);
    end

endmodule

FILE: hw/rtl/chbd_checker.sv
// Port-level checks for the bank and DMA register block, bound to the top level.
module chbd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_dma_start,
    input logic [1:0]  o_dma_error,
    input logic [11:0] o_dma_length
);
    import chbd_pkg::*;

    // back-pressure only comes from a held result
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output register");

    // an accepted request shows up next cycle
    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted request produced no result");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result dropped");

    a_start_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_dma_start) |-> (o_dma_error == DMA_ERR_OK && o_dma_length != 12'd0))
        else $error("transfer started with error or zero length");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind color_handheld_bank_and_dma_regs chbd_checker u_chbd_checker (.*);

FILE: test/testbench.sv
// Self-checking testbench for the bank and DMA register block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import chbd_pkg::*;

    localparam logic [3:0] REG_NONE_FIRST = 4'd9;
    localparam logic [3:0] REG_NONE_MID   = 4'd12;
    localparam logic [3:0] REG_NONE_LAST  = 4'd15;
    localparam logic [CFG_ADDR_W-1:0] CFG_INV_READ = '0;
    localparam logic [15:0] VRAM_BASE = 16'h8000;

    typedef struct packed {
        logic [7:0] rd;
        logic       vb;
        logic [2:0] wb;
        t_dma_req   dma;
    } t_bank_dma_result;

    typedef struct packed {
        logic             cmd;
        logic [3:0]       idx;
        logic [7:0]       data;
        logic             fixed;
        t_bank_dma_result res;
    } t_bus_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_command = CMD_READ;
    logic [3:0]  i_reg_index = REG_VBANK;
    logic [7:0]  i_write_data = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_read_data;
    logic        o_vram_bank_sel;
    logic [2:0]  o_wram_bank_sel;
    logic        o_dma_start;
    logic [15:0] o_dma_source;
    logic [15:0] o_dma_dest;
    logic [11:0] o_dma_length;
    logic [1:0]  o_dma_error;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    color_handheld_bank_and_dma_regs dut (.*);

    always #1 i_clk = ~i_clk;

    // predicted register state
    logic [7:0]  vbank_q = '0;
    logic [7:0]  speed_q = '0;
    logic [15:0] src_q = '0;
    logic [12:0] dst_q = '0;
    logic [7:0]  ctrl_q = '0;
    logic [7:0]  ir_q = '0;
    logic [2:0]  wbank_q = '0;
    logic [7:0]  unk_read_q = INV_READ_RST;

    t_bank_dma_result pending_results[$];
    int mismatches = 0;
    int req_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_go = 1'b0;
    logic hold_off = 1'b0;

    t_bus_row dir_rows [0:25] = '{
        '{CMD_READ,  REG_VBANK,      8'h00, 1'b1, '{8'hFE, 1'b0, 3'd0, '0}},
        '{CMD_READ,  REG_SPEED,      8'hFF, 1'b1, '{8'h00, 1'b0, 3'd0, '0}},
        // work bank reads zero until first written
        '{CMD_READ,  REG_WBANK,      8'h00, 1'b1, '{8'h00, 1'b0, 3'd0, '0}},
        '{CMD_READ,  REG_DMA5,       8'h00, 1'b1, '{8'hFF, 1'b0, 3'd0, '0}},
        '{CMD_READ,  REG_NONE_FIRST, 8'h00, 1'b1, '{8'hFF, 1'b0, 3'd0, '0}},
        '{CMD_READ,  REG_NONE_LAST,  8'hFF, 1'b1, '{8'hFF, 1'b0, 3'd0, '0}},
        // bank 0 maps to 1
        '{CMD_WRITE, REG_WBANK,      8'h00, 1'b1, '{8'h00, 1'b0, 3'd1, '0}},
        '{CMD_READ,  REG_WBANK,      8'h00, 1'b1, '{8'h01, 1'b0, 3'd1, '0}},
        '{CMD_WRITE, REG_WBANK,      8'hFF, 1'b1, '{8'h00, 1'b0, 3'd7, '0}},
        '{CMD_WRITE, REG_VBANK,      8'hFF, 1'b1, '{8'h00, 1'b1, 3'd7, '0}},
        '{CMD_READ,  REG_VBANK,      8'h00, 1'b1, '{8'hFF, 1'b1, 3'd7, '0}},
        '{CMD_WRITE, REG_VBANK,      8'h00, 1'b0, '0},
        '{CMD_WRITE, REG_SPEED,      8'hFF, 1'b0, '0},
        '{CMD_READ,  REG_SPEED,      8'h00, 1'b0, '0},
        '{CMD_WRITE, REG_IR,         8'hA5, 1'b0, '0},
        '{CMD_READ,  REG_IR,         8'h00, 1'b0, '0},
        '{CMD_WRITE, REG_DMA1,       8'hFF, 1'b0, '0},
        '{CMD_WRITE, REG_DMA2,       8'hFF, 1'b0, '0},
        '{CMD_READ,  REG_DMA2,       8'h00, 1'b0, '0},
        // source 0xFFF0 is in the upper forbidden window
        '{CMD_WRITE, REG_DMA5,       8'h7F, 1'b1,
          '{8'h00, 1'b0, 3'd7, '{1'b0, 16'hFFF0, 16'h8000, 12'h800, DMA_ERR_SRC}}},
        '{CMD_WRITE, REG_DMA1,       8'h00, 1'b0, '0},
        '{CMD_WRITE, REG_DMA2,       8'h00, 1'b0, '0},
        '{CMD_WRITE, REG_DMA3,       8'hFF, 1'b0, '0},
        '{CMD_WRITE, REG_DMA4,       8'hFF, 1'b0, '0},
        // top of video RAM, shortest length
        '{CMD_WRITE, REG_DMA5,       8'h80, 1'b1,
          '{8'h00, 1'b0, 3'd7, '{1'b1, 16'h0000, 16'h9FF0, 12'h010, DMA_ERR_OK}}},
        '{CMD_WRITE, REG_NONE_MID,   8'h55, 1'b0, '0}
    };

    function automatic t_bank_dma_result predict_bus_access(input logic cmd,
                                                            input logic [3:0] idx,
                                                            input logic [7:0] data);
        t_bank_dma_result r;
        r = '0;
        if (cmd == CMD_READ) begin
            case (idx)
                REG_VBANK: r.rd = {VBANK_RD_FILL, vbank_q[0]};
                REG_SPEED: r.rd = speed_q;
                REG_DMA1:  r.rd = src_q[15:8];
                REG_DMA2:  r.rd = src_q[7:0];
                REG_DMA3:  r.rd = {3'b000, dst_q[12:8]};
                REG_DMA4:  r.rd = dst_q[7:0];
                REG_DMA5:  r.rd = CTRL_READ;
                REG_IR:    r.rd = ir_q;
                REG_WBANK: r.rd = {5'b00000, wbank_q};
                default:   r.rd = unk_read_q;
            endcase
        end else begin
            case (idx)
                REG_VBANK: vbank_q = data;
                REG_SPEED: speed_q = data;
                REG_DMA1:  src_q[15:8] = data;
                REG_DMA2:  src_q[7:0] = data & SRC_LO_MASK;
                REG_DMA3:  dst_q[12:8] = data[4:0] & DST_HI_MASK;
                REG_DMA4:  dst_q[7:0] = data & DST_LO_MASK;
                REG_DMA5: begin
                    ctrl_q = data;
                    r.dma.source = src_q;
                    r.dma.dest = VRAM_BASE + {3'b000, dst_q};
                    r.dma.length = {({1'b0, data[6:0] & LEN_MASK} + 8'd1), 4'h0};
                    if ((src_q >= SRC_BAD1_LO && src_q <= SRC_BAD1_HI) || src_q >= SRC_BAD2_LO)
                        r.dma.error = DMA_ERR_SRC;
                    else if (dst_q > DST_OFS_MAX)
                        r.dma.error = DMA_ERR_DST;
                    else begin
                        r.dma.start = 1'b1;
                        ctrl_q[7] = 1'b1;
                    end
                end
                REG_IR:    ir_q = data;
                REG_WBANK: wbank_q = (data[2:0] == 3'd0) ? 3'd1 : data[2:0];
                default: ;
            endcase
        end
        r.vb = vbank_q[0];
        r.wb = wbank_q;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h got %h", what, want, got);
    endtask

    task automatic check_result();
        t_bank_dma_result want;
        if (pending_results.size() == 0) begin
            note_mismatch("result with no request pending", 16'h0, 16'h0);
            return;
        end
        want = pending_results.pop_front();
        if (o_read_data !== want.rd)
            note_mismatch("read_data", 16'(want.rd), 16'(o_read_data));
        if (o_vram_bank_sel !== want.vb)
            note_mismatch("vram_bank_sel", 16'(want.vb), 16'(o_vram_bank_sel));
        if (o_wram_bank_sel !== want.wb)
            note_mismatch("wram_bank_sel", 16'(want.wb), 16'(o_wram_bank_sel));
        if (o_dma_start !== want.dma.start)
            note_mismatch("dma_start", 16'(want.dma.start), 16'(o_dma_start));
        if (o_dma_source !== want.dma.source)
            note_mismatch("dma_source", want.dma.source, o_dma_source);
        if (o_dma_dest !== want.dma.dest) note_mismatch("dma_dest", want.dma.dest, o_dma_dest);
        if (o_dma_length !== want.dma.length)
            note_mismatch("dma_length", 16'(want.dma.length), 16'(o_dma_length));
        if (o_dma_error !== want.dma.error)
            note_mismatch("dma_error", 16'(want.dma.error), 16'(o_dma_error));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            check_result();
    end

    always @(posedge i_clk) begin
        i_out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
    end

    // long receiver hold-off so the output fills and the input stalls
    initial begin
        wait (hold_go);
        repeat (80) begin
            @(posedge i_clk);
            hold_off <= 1'b1;
        end
        @(posedge i_clk);
        hold_off <= 1'b0;
    end

    task automatic send_req(input logic cmd, input logic [3:0] idx, input logic [7:0] data,
                            input logic fixed, input t_bank_dma_result fixed_res);
        t_bank_dma_result want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_reg_index <= idx;
        i_write_data <= data;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        want = predict_bus_access(cmd, idx, data);
        pending_results.push_back(fixed ? fixed_res : want);
        if (!(cmd == CMD_WRITE && idx > REG_WBANK))
            req_count++;
    endtask

    task automatic access(input logic cmd, input logic [3:0] idx, input logic [7:0] data);
        send_req(cmd, idx, data, 1'b0, '0);
    endtask

    task automatic dma_sequence();
        logic [7:0] src_hi_corners [0:7] = '{8'h00, 8'h7F, 8'h80, 8'h9F,
                                             8'hA0, 8'hDF, 8'hE0, 8'hFF};
        logic [7:0] hi;
        hi = ($urandom_range(0, 3) == 0) ? src_hi_corners[$urandom_range(0, 7)]
                                         : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 85) access(CMD_WRITE, REG_DMA1, hi);
        if ($urandom_range(0, 99) < 85) access(CMD_WRITE, REG_DMA2, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 70) access(CMD_WRITE, REG_DMA3, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 70) access(CMD_WRITE, REG_DMA4, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 30)
            access(CMD_READ, 4'($urandom_range(REG_DMA1, REG_DMA4)), 8'($urandom_range(0, 255)));
        access(CMD_WRITE, REG_DMA5, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 30) access(CMD_READ, REG_DMA5, 8'($urandom_range(0, 255)));
    endtask

    task automatic random_traffic(input int target);
        req_count = 0;
        while (req_count < target) begin
            if ($urandom_range(0, 99) < 60)
                dma_sequence();
            else
                access(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                       8'($urandom_range(0, 255)));
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // APB write then read back; block must be idle
    task automatic cfg_write(input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_INV_READ;
        pwdata <= {24'h0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        unk_read_q = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[7:0] !== value)
            note_mismatch("invalid_read_value readback", 16'(value), 16'(prdata[7:0]));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 15;
        recv_idle_pct = 76;
        foreach (dir_rows[k])
            send_req(dir_rows[k].cmd, dir_rows[k].idx, dir_rows[k].data,
                     dir_rows[k].fixed, dir_rows[k].res);
        drain();

        cfg_write(8'h00);
        hold_go = 1'b1;
        random_traffic(180);
        drain();

        send_idle_pct = 76;
        recv_idle_pct = 15;
        cfg_write(8'hA5);
        random_traffic(180);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        cfg_write(8'hFF);
        random_traffic(180);
        drain();

        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/chbd_pkg.sv
hw/rtl/chbd_dma_check.sv
hw/rtl/color_handheld_bank_and_dma_regs.sv
hw/rtl/chbd_checker.sv
test/testbench.sv
